// ===== src/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrd_pkg
// shared types and constants of the log record deframer
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // register byte addresses
  localparam logic [AddrW-1:0] ADDR_LOG_TYPE   = 4'h0;
  localparam logic [AddrW-1:0] ADDR_FILE_START = 4'h4;
  localparam logic [AddrW-1:0] ADDR_FILE_END   = 4'h8;

  localparam logic [15:0] RST_LOG_TYPE   = 16'd1;
  localparam logic [15:0] RST_FILE_START = 16'd2;
  localparam logic [15:0] RST_FILE_END   = 16'd3;

  localparam logic [15:0] TYPE_BYTES  = 16'd2;
  localparam logic [15:0] STAMP_BYTES = 16'd8;

  typedef struct packed {
    logic [15:0] log_type_code;
    logic [15:0] file_start_code;
    logic [15:0] file_end_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [63:0] record_timestamp;
  } result_t;

endpackage

// ===== src/log_record_deframer.sv =====
// ----------------------------------------------------------------------------
// log_record_deframer
// byte-serial deframer for typed log records with timestamp and payload
// ----------------------------------------------------------------------------
// One stream byte is taken per transfer and one byte per clock is sustained
// while in_stall_o is low: the parser state updates in the cycle the byte is
// accepted. A payload byte is registered into the result register, or into
// the skid entry when that register holds a stalled result. The single skid
// entry lets input keep flowing while a result waits; in_stall_o rises only
// when both entries hold results and then drops the cycle after the output
// moves. Records are a 16-bit little-endian type and a 16-bit signed length.
// Log records carry an 8-byte timestamp and length-8 payload bytes, each
// sent with the raw timestamp and a last mark on the final one. File
// start/end records have their body skipped; unknown types return to the
// header. The type codes live in APB registers at 0x0, 0x4, 0x8 and should
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module log_record_deframer import lrd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // apb configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // byte stream in
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  // payload out
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             payload_last_o,
  output logic [63:0]      record_timestamp_o
);

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    buf_full;

  // a valid byte is transferred whenever the skid entry is free
  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i & ~buf_full;

  lrd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // record parser, one byte per accepted transfer
  lrd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (in_accept),
    .in_byte_i   (in_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register plus skid entry decouples the two sides
  lrd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign payload_byte_o     = out_data.payload_byte;
  assign payload_last_o     = out_data.payload_last;
  assign record_timestamp_o = out_data.record_timestamp;

endmodule

// ===== src/lrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lrd_cfg_regs
// apb register file holding the three record type codes
// ----------------------------------------------------------------------------
module lrd_cfg_regs import lrd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.log_type_code   <= RST_LOG_TYPE;
      cfg_q.file_start_code <= RST_FILE_START;
      cfg_q.file_end_code   <= RST_FILE_END;
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_LOG_TYPE:   cfg_q.log_type_code   <= pwdata[15:0];
        ADDR_FILE_START: cfg_q.file_start_code <= pwdata[15:0];
        ADDR_FILE_END:   cfg_q.file_end_code   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // codes read back sign extended
  always_comb begin
    unique case (paddr)
      ADDR_LOG_TYPE:   prdata = {{16{cfg_q.log_type_code[15]}}, cfg_q.log_type_code};
      ADDR_FILE_START: prdata = {{16{cfg_q.file_start_code[15]}}, cfg_q.file_start_code};
      ADDR_FILE_END:   prdata = {{16{cfg_q.file_end_code[15]}}, cfg_q.file_end_code};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== src/lrd_core.sv =====
// ----------------------------------------------------------------------------
// lrd_core
// per-byte record parser: header, timestamp, payload and skip phases
// ----------------------------------------------------------------------------
module lrd_core import lrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_LEN   = 3'd1,
    PH_STAMP = 3'd2,
    PH_BODY  = 3'd3,
    PH_SKIP  = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [15:0] kind_q, kind_d;
  logic [15:0] len_q, len_d;
  logic [63:0] ts_q, ts_d;

  logic        first_byte;
  logic        left_one;
  logic [15:0] word;
  logic [15:0] left_dec;
  logic [16:0] body_len;

  assign first_byte = (left_q >= TYPE_BYTES);
  assign left_one   = (left_q <= 16'd1);
  assign word       = {in_byte_i, hdr_q};
  assign left_dec   = left_q - 16'd1;
  assign body_len   = {len_q[15], len_q} - {1'b0, STAMP_BYTES};

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    hdr_d       = hdr_q;
    kind_d      = kind_q;
    len_d       = len_q;
    ts_d        = ts_q;
    res_valid_o = 1'b0;
    res_o.payload_byte     = in_byte_i;
    res_o.payload_last     = left_one;
    res_o.record_timestamp = ts_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_LEN: begin
          if (first_byte) begin
            hdr_d  = in_byte_i;
            left_d = 16'd1;
          end else begin
            len_d = word;
            if (kind_q == cfg_i.log_type_code) begin
              phase_d = PH_STAMP;
              left_d  = STAMP_BYTES;
            end else if (kind_q == cfg_i.file_start_code ||
                         kind_q == cfg_i.file_end_code) begin
              if ($signed(word) > 16'sd0) begin
                phase_d = PH_SKIP;
                left_d  = word;
              end else begin
                phase_d = PH_TYPE;
                left_d  = TYPE_BYTES;
              end
            end else begin
              phase_d = PH_TYPE;
              left_d  = TYPE_BYTES;
            end
          end
        end
        PH_STAMP: begin
          ts_d   = {in_byte_i, ts_q[63:8]};
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            if ($signed(body_len) > 17'sd0) begin
              phase_d = PH_BODY;
              left_d  = body_len[15:0];
            end else begin
              phase_d = PH_TYPE;
              left_d  = TYPE_BYTES;
            end
          end
        end
        PH_BODY, PH_SKIP: begin
          res_valid_o = (phase_q == PH_BODY);
          if (left_one) begin
            phase_d = PH_TYPE;
            left_d  = TYPE_BYTES;
          end else begin
            left_d = left_dec;
          end
        end
        default: begin
          // type field; stray codes restart the header here too
          if (first_byte || phase_q != PH_TYPE) begin
            phase_d = PH_TYPE;
            hdr_d   = in_byte_i;
            left_d  = 16'd1;
          end else begin
            kind_d  = word;
            phase_d = PH_LEN;
            left_d  = TYPE_BYTES;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      left_q  <= TYPE_BYTES;
      hdr_q   <= '0;
      kind_q  <= '0;
      len_q   <= '0;
      ts_q    <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      hdr_q   <= hdr_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      ts_q    <= ts_d;
    end
  end

endmodule

// ===== src/lrd_out_buf.sv =====
// ----------------------------------------------------------------------------
// lrd_out_buf
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
module lrd_out_buf import lrd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop         = main_valid_q & ~out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule

// ===== src/lrd_checker.sv =====
// ----------------------------------------------------------------------------
// lrd_checker
// port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
module lrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  payload_byte_o,
  input logic        payload_last_o,
  input logic [63:0] record_timestamp_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) &&
      $stable(payload_last_o) && $stable(record_timestamp_o))
    else $error("stalled result changed");

  // input stall only with a waiting result
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // input stall only follows an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without downstream stall");

  // stall releases after the result moves
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after output transfer");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind log_record_deframer lrd_checker u_lrd_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the log record deframer
// ----------------------------------------------------------------------------
// Bytes are pushed over the valid/stall input channel and every accepted byte
// runs through a local copy of the record parser. Payload bytes it expects are
// queued and compared field by field with each output transfer. Type codes
// are changed over the apb port between phases, always with the stream at a
// header boundary and the output drained. Idling on both sides is varied per
// phase, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import lrd_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int ShownErrors = 10;

  // parser phases of the local record model
  typedef enum logic [2:0] {
    AWAIT_TYPE,
    AWAIT_LEN,
    GATHER_STAMP,
    PASS_BODY,
    SKIP_BODY
  } parse_phase_e;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [7:0]       in_byte_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       payload_byte_o;
  logic             payload_last_o;
  logic [63:0]      record_timestamp_o;

  // local copy of the type codes and of the parser state
  cfg_t         code_model;
  parse_phase_e parse_phase;
  logic [15:0]  left_cnt;
  logic [15:0]  hdr_lo;
  logic [15:0]  kind_word;
  logic [15:0]  len_word;
  logic [63:0]  stamp_bits;

  // payload bytes predicted but not yet seen on the output
  result_t pending_payload[$];

  int stream_bytes     = 0;
  int payloads_seen    = 0;
  int mismatch_count   = 0;
  int settings_applied = 0;

  // idling knobs, percent per cycle
  int send_gap_pct = 0;
  int stall_pct    = 0;
  // long output hold-off, counted down by the stall process
  int hold_cycles  = 0;

  log_record_deframer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_byte_i          (in_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .payload_byte_o     (payload_byte_o),
    .payload_last_o     (payload_last_o),
    .record_timestamp_o (record_timestamp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // record parser model
  // --------------------------------------------------------------------------

  function automatic void reset_parser();
    code_model.log_type_code   = RST_LOG_TYPE;
    code_model.file_start_code = RST_FILE_START;
    code_model.file_end_code   = RST_FILE_END;
    parse_phase = AWAIT_TYPE;
    left_cnt    = TYPE_BYTES;
    hdr_lo      = '0;
    kind_word   = '0;
    len_word    = '0;
    stamp_bits  = '0;
  endfunction

  // advances the parser by one stream byte; returns 1 when a payload byte
  // comes out of it
  function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
    int body_len;
    res = '0;
    case (parse_phase)
      AWAIT_LEN: begin
        if (left_cnt >= TYPE_BYTES) begin
          hdr_lo   = {8'h00, b};
          left_cnt = 16'd1;
        end else begin
          len_word = {b, hdr_lo[7:0]};
          // log code wins over the file codes when they overlap
          if (kind_word == code_model.log_type_code) begin
            parse_phase = GATHER_STAMP;
            left_cnt    = STAMP_BYTES;
          end else if (kind_word == code_model.file_start_code ||
                       kind_word == code_model.file_end_code) begin
            // empty notice goes straight back to the header
            if ($signed(len_word) > 0) begin
              parse_phase = SKIP_BODY;
              left_cnt    = len_word;
            end else begin
              parse_phase = AWAIT_TYPE;
              left_cnt    = TYPE_BYTES;
            end
          end else begin
            // unknown type, no body
            parse_phase = AWAIT_TYPE;
            left_cnt    = TYPE_BYTES;
          end
        end
      end
      GATHER_STAMP: begin
        stamp_bits = {b, stamp_bits[63:8]};
        left_cnt   = left_cnt - 16'd1;
        if (left_cnt == 16'd0) begin
          body_len = int'($signed(len_word)) - int'(STAMP_BYTES);
          // short log record ends right after its timestamp
          if (body_len > 0) begin
            parse_phase = PASS_BODY;
            left_cnt    = body_len[15:0];
          end else begin
            parse_phase = AWAIT_TYPE;
            left_cnt    = TYPE_BYTES;
          end
        end
      end
      PASS_BODY: begin
        res.payload_byte     = b;
        res.payload_last     = (left_cnt <= 16'd1);
        res.record_timestamp = stamp_bits;
        if (left_cnt <= 16'd1) begin
          parse_phase = AWAIT_TYPE;
          left_cnt    = TYPE_BYTES;
        end else begin
          left_cnt = left_cnt - 16'd1;
        end
        return 1'b1;
      end
      SKIP_BODY: begin
        if (left_cnt <= 16'd1) begin
          parse_phase = AWAIT_TYPE;
          left_cnt    = TYPE_BYTES;
        end else begin
          left_cnt = left_cnt - 16'd1;
        end
      end
      default: begin
        if (left_cnt >= TYPE_BYTES) begin
          hdr_lo   = {8'h00, b};
          left_cnt = 16'd1;
        end else begin
          kind_word   = {b, hdr_lo[7:0]};
          parse_phase = AWAIT_LEN;
          left_cnt    = TYPE_BYTES;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // bytes that follow the header of a well-formed record under current codes
  function automatic int body_for(input logic [15:0] kind, input logic [15:0] len);
    int slen;
    slen = int'($signed(len));
    if (kind == code_model.log_type_code)
      return int'(STAMP_BYTES) + ((slen > int'(STAMP_BYTES)) ? slen - int'(STAMP_BYTES) : 0);
    if (kind == code_model.file_start_code || kind == code_model.file_end_code)
      return (slen > 0) ? slen : 0;
    return 0;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= ShownErrors)
      $display("%0t ns: payload error: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------

  // random stall, or a long hold-off while hold_cycles runs down
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare every output transfer with the oldest predicted payload byte
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      payloads_seen++;
      if (pending_payload.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0b stamp %016h",
                                payload_byte_o, payload_last_o, record_timestamp_o));
      end else begin
        want = pending_payload.pop_front();
        if (payload_byte_o !== want.payload_byte ||
            payload_last_o !== want.payload_last ||
            record_timestamp_o !== want.record_timestamp)
          note_mismatch($sformatf(
            "expected byte %02h last %0b stamp %016h, got byte %02h last %0b stamp %016h",
            want.payload_byte, want.payload_last, want.record_timestamp,
            payload_byte_o, payload_last_o, record_timestamp_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side and configuration
  // --------------------------------------------------------------------------

  // one byte transfer; valid stays high afterwards until the next call or an
  // explicit idle lowers it
  task automatic push_byte(input logic [7:0] b);
    result_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    stream_bytes++;
    if (deframe_byte(b, res))
      pending_payload = {pending_payload, res};
  endtask

  task automatic send_record(input logic [15:0] kind, input logic [15:0] len,
                             input int body_n);
    push_byte(kind[7:0]);
    push_byte(kind[15:8]);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    repeat (body_n) push_byte(8'($urandom));
  endtask

  task automatic push_list(input logic [7:0] seq[$]);
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // stop sending, let every predicted byte come out, then allow for a result
  // still in flight inside the block
  task automatic wait_block_idle();
    in_valid_i <= 1'b0;
    while (pending_payload.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_code(input logic [AddrW-1:0] addr, input logic [15:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{16{code[15]}}, code};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      ADDR_LOG_TYPE:   code_model.log_type_code   = code;
      ADDR_FILE_START: code_model.file_start_code = code;
      ADDR_FILE_END:   code_model.file_end_code   = code;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_codes(input logic [15:0] log_code, input logic [15:0] start_code,
                           input logic [15:0] end_code);
    wait_block_idle();
    write_code(ADDR_LOG_TYPE, log_code);
    write_code(ADDR_FILE_START, start_code);
    write_code(ADDR_FILE_END, end_code);
    settings_applied++;
  endtask

  // one random record, mostly well-formed, sometimes noise or cut short
  task automatic random_record();
    logic [15:0] kind;
    logic [15:0] len;
    int pick;
    int body_n;
    pick = $urandom_range(99);
    if (pick < 5) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      return;
    end
    if (pick < 55)      kind = code_model.log_type_code;
    else if (pick < 70) kind = code_model.file_start_code;
    else if (pick < 80) kind = code_model.file_end_code;
    else                kind = 16'($urandom);
    pick = $urandom_range(99);
    if (kind == code_model.log_type_code) begin
      if (pick < 75)      len = STAMP_BYTES + 16'($urandom_range(1, 16));
      else if (pick < 90) len = 16'($urandom_range(0, 8));
      else                len = {1'b1, 15'($urandom)};
    end else begin
      if (pick < 80)      len = 16'($urandom_range(0, 12));
      else if (pick < 90) len = {1'b1, 15'($urandom)};
      else                len = 16'($urandom_range(13, 60));
    end
    body_n = body_for(kind, len);
    // truncated record: next header starts inside the body
    if (body_n > 0 && $urandom_range(99) < 4)
      body_n = $urandom_range(0, body_n - 1);
    send_record(kind, len, body_n);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // log record with extreme stamp and payload bytes, unknown type, empty
  // notice and a one-byte skip, all under the reset codes
  task automatic test_basic_records();
    push_list('{8'h01, 8'h00, 8'h0A, 8'h00,
                8'h80, 8'hFF, 8'h00, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA,
                8'h00, 8'hFF});
    push_list('{8'hFF, 8'hFF, 8'hFF, 8'h7F});
    push_list('{8'h02, 8'h00, 8'h00, 8'h00});
    push_list('{8'h03, 8'h00, 8'h01, 8'h00, 8'h5A});
    wait_block_idle();
  endtask

  // all three codes equal: log handling must win, with a short negative
  // length log record and then one with a single payload byte
  task automatic test_overlapping_codes();
    set_codes(16'h8000, 16'h8000, 16'h8000);
    send_record(16'h8000, 16'hFFF8, int'(STAMP_BYTES));
    send_record(16'h8000, 16'd9, int'(STAMP_BYTES) + 1);
    wait_block_idle();
  endtask

  task automatic test_random_traffic(input int n_bytes, input int gap, input int stall);
    int start_cnt;
    send_gap_pct = gap;
    stall_pct    = stall;
    start_cnt    = stream_bytes;
    while (stream_bytes - start_cnt < n_bytes) random_record();
    // finish any partial record so codes change only at a header boundary
    while (!(parse_phase == AWAIT_TYPE && left_cnt == TYPE_BYTES)) push_byte(8'h00);
    wait_block_idle();
    send_gap_pct = 0;
    stall_pct    = 0;
  endtask

  // output held off for a long stretch while long log records keep coming,
  // so the block fills up and stalls its input
  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (3) send_record(code_model.log_type_code, STAMP_BYTES + 16'd24,
                           int'(STAMP_BYTES) + 24);
    wait_block_idle();
  endtask

  // sender stops after each record until the output has caught up
  task automatic test_sender_pause();
    stall_pct = 47;
    repeat (6) begin
      send_record(code_model.log_type_code, STAMP_BYTES + 16'($urandom_range(1, 12)), 0);
      while (!(parse_phase == AWAIT_TYPE && left_cnt == TYPE_BYTES)) push_byte(8'($urandom));
      in_valid_i <= 1'b0;
      while (pending_payload.size() != 0) @(posedge clk_i);
      @(posedge clk_i);
    end
    wait_block_idle();
    stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------

  initial begin
    reset_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_records();
    test_random_traffic(200, 0, 0);
    test_overlapping_codes();
    set_codes(16'h7FFF, 16'h8000, 16'h0000);
    test_random_traffic(200, 47, 0);
    set_codes(16'hFFFF, 16'hFFFE, 16'h7FFF);
    test_random_traffic(200, 0, 47);
    set_codes(16'($urandom_range(0, 7)), 16'($urandom), 16'($urandom_range(0, 7)));
    test_random_traffic(200, 27, 27);
    test_backpressure();
    test_sender_pause();

    wait_block_idle();
    repeat (8) @(posedge clk_i);
    while (pending_payload.size() != 0) begin
      result_t lost;
      lost = pending_payload.pop_front();
      note_mismatch($sformatf("byte %02h last %0b stamp %016h never came out",
                              lost.payload_byte, lost.payload_last,
                              lost.record_timestamp));
    end

    $display("covered %0d stream bytes and %0d payload transfers under %0d code settings",
             stream_bytes, payloads_seen, settings_applied + 1);
    $display("idling phases: none, sender gaps, output stalls, both, long hold-off");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d payload errors", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", QuietLimit);
    $display("Mismatches found");
    $finish;
  end

endmodule
